### rtl/pdf_pkg.sv
// Shared types and constants for the packet duplicate filter.
// Used by every module of the block; no dependencies of its own.
package pdf_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam int HEAD_W = 8;
  localparam int REST_W = 64;
  localparam int SEQ_W = 32;
  localparam int TIME_W = 32;
  localparam int EXP_W = 16;
  localparam int STATUS_W = 3;

  localparam logic [EXP_W-1:0] EXPIRE_RESET = EXP_W'(100);

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_QUERY = 3'd4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [REST_W-1:0] rest;
    logic [SEQ_W-1:0] seq;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic en;
    logic [IDX_W-1:0] addr;
    entry_t data;
  } wr_req_t;

  typedef struct packed {
    logic key_eq;
    logic expired;
    logic seq_ge;
  } cmp_t;

endpackage

### rtl/pdf_table.sv
// Entry store of the duplicate filter: one-port-write, one-port-read memory
// with registered read data, plus per-entry valid flops cleared by reset.
// Depends on pdf_pkg.
module pdf_table (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [pdf_pkg::IDX_W-1:0] rd_addr,
  output pdf_pkg::entry_t          rd_data,
  output logic                     rd_vbit,
  input  pdf_pkg::wr_req_t         wr
);
  import pdf_pkg::*;

  entry_t mem [ENTRIES];
  logic [ENTRIES-1:0] vbits;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vbits <= '0;
      rd_vbit <= 1'b0;
    end else begin
      if (wr.en) begin
        vbits[wr.addr] <= 1'b1;
      end
      rd_vbit <= vbits[rd_addr];
    end
  end

endmodule

### rtl/pdf_cmp.sv
// Shared compare unit: key match, expiry age test and sequence compare
// against one stored entry per cycle. Depends on pdf_pkg.
module pdf_cmp (
  input  pdf_pkg::entry_t                 entry,
  input  logic [pdf_pkg::HEAD_W-1:0]      head,
  input  logic [pdf_pkg::REST_W-1:0]      rest,
  input  logic [pdf_pkg::SEQ_W-1:0]       seqno,
  input  logic [pdf_pkg::TIME_W-1:0]      now,
  input  logic [pdf_pkg::EXP_W-1:0]       expire_seconds,
  output pdf_pkg::cmp_t                   res
);
  import pdf_pkg::*;

  logic [TIME_W-1:0] age;

  // age wraps modulo 2^32, so a stamp ahead of now reads as very old
  assign age = now - entry.stamp;

  always_comb begin
    res.key_eq = (entry.head == head) && (entry.rest == rest);
    res.expired = age > TIME_W'(expire_seconds);
    res.seq_ge = entry.seq >= seqno;
  end

endmodule

### rtl/pdf_ctrl.sv
// Sequencer of the duplicate filter: holds the item, walks the table one
// entry a cycle through the compare unit, decides, writes back and holds
// the result. Depends on pdf_pkg and pdf_cmp.
module pdf_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [pdf_pkg::HEAD_W-1:0]    plate_head,
  input  logic [pdf_pkg::REST_W-1:0]    plate_rest,
  input  logic [pdf_pkg::SEQ_W-1:0]     seqno,
  input  logic [pdf_pkg::TIME_W-1:0]    stamp,
  input  logic [pdf_pkg::TIME_W-1:0]    now,
  input  logic [pdf_pkg::EXP_W-1:0]     expire_seconds,
  output logic [pdf_pkg::IDX_W-1:0]     rd_addr,
  input  pdf_pkg::entry_t               rd_data,
  input  logic                          rd_vbit,
  output pdf_pkg::wr_req_t              wr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pdf_pkg::STATUS_W-1:0]  status,
  output logic                          seen
);
  import pdf_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LAST = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // held item
  logic item_mode;
  logic [HEAD_W-1:0] item_head;
  logic [REST_W-1:0] item_rest;
  logic [SEQ_W-1:0] item_seq;
  logic [TIME_W-1:0] item_stamp;
  logic [TIME_W-1:0] item_now;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] rd_idx;
  logic rd_live;

  logic hit;
  logic [IDX_W-1:0] hit_idx;
  logic hit_expired;
  logic hit_seq_ge;
  logic free;
  logic [IDX_W-1:0] free_idx;

  cmp_t cmp;
  logic in_xfer;
  logic out_load;
  logic [STATUS_W-1:0] status_next;
  logic seen_next;

  pdf_cmp u_cmp (
    .entry          (rd_data),
    .head           (item_head),
    .rest           (item_rest),
    .seqno          (item_seq),
    .now            (item_now),
    .expire_seconds (expire_seconds),
    .res            (cmp)
  );

  assign in_stall = (state != S_IDLE);
  assign in_xfer = in_valid && !in_stall;
  assign rd_addr = scan_idx;
  assign out_load = (state == S_DECIDE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_xfer) state_next = S_SCAN;
      S_SCAN:   if (scan_idx == LAST_IDX) state_next = S_LAST;
      S_LAST:   state_next = S_DECIDE;
      S_DECIDE: if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // decision on the scan results
  always_comb begin
    wr.en = 1'b0;
    wr.addr = free_idx;
    wr.data.head = item_head;
    wr.data.rest = item_rest;
    wr.data.seq = item_seq;
    wr.data.stamp = item_stamp;
    seen_next = 1'b0;
    status_next = ST_FULL;
    if (item_mode == MODE_QUERY) begin
      status_next = ST_QUERY;
      seen_next = hit && !hit_expired && hit_seq_ge;
    end else if (hit) begin
      wr.addr = hit_idx;
      if (hit_expired || !hit_seq_ge) begin
        wr.en = out_load;
        status_next = ST_REPLACED;
      end else begin
        status_next = ST_REJECTED;
      end
    end else if (free) begin
      wr.en = out_load;
      status_next = ST_INSERTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      scan_idx <= '0;
      rd_live <= 1'b0;
      hit <= 1'b0;
      free <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_live <= (state == S_SCAN);
      if (in_xfer) begin
        scan_idx <= '0;
        hit <= 1'b0;
        free <= 1'b0;
      end else begin
        if (state == S_SCAN) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (rd_live) begin
          // keep the lowest-index match and the lowest free slot
          if (rd_vbit && cmp.key_eq && !hit) begin
            hit <= 1'b1;
          end
          if (!rd_vbit && !free) begin
            free <= 1'b1;
          end
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_idx;
    if (in_xfer) begin
      item_mode <= mode;
      item_head <= plate_head;
      item_rest <= plate_rest;
      item_seq <= seqno;
      item_stamp <= stamp;
      item_now <= now;
    end
    if (rd_live && rd_vbit && cmp.key_eq && !hit) begin
      hit_idx <= rd_idx;
      hit_expired <= cmp.expired;
      hit_seq_ge <= cmp.seq_ge;
    end
    if (rd_live && !rd_vbit && !free) begin
      free_idx <= rd_idx;
    end
    if (out_load) begin
      status <= status_next;
      seen <= seen_next;
    end
  end

endmodule

### rtl/packet_duplicate_filter_top.sv
// Top level of the packet duplicate filter: expiry register, entry table
// and scan sequencer. Depends on pdf_pkg, pdf_table and pdf_ctrl.
//
//   channel  direction  handshake              payload
//   in       to block   in_valid / in_stall    mode plate_head plate_rest seqno stamp now
//   out      from block out_valid / out_stall  status seen
//   cfg      to block   cfg_we                 cfg_wdata (expire_seconds)
//
// For each transferred item the table is walked one entry a cycle through a
// single read port and a single compare unit; the decide step then decides
// and writes back. A waiting result does not block the next transfer; a new
// result waits in the decide step until the output register is free.
// Reset (rst, synchronous) empties the table at once and sets
// expire_seconds to 100.
module packet_duplicate_filter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [pdf_pkg::HEAD_W-1:0]    plate_head,
  input  logic [pdf_pkg::REST_W-1:0]    plate_rest,
  input  logic [pdf_pkg::SEQ_W-1:0]     seqno,
  input  logic [pdf_pkg::TIME_W-1:0]    stamp,
  input  logic [pdf_pkg::TIME_W-1:0]    now,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pdf_pkg::STATUS_W-1:0]  status,
  output logic                          seen,
  input  logic                          cfg_we,
  input  logic [pdf_pkg::EXP_W-1:0]     cfg_wdata
);
  import pdf_pkg::*;

  logic [EXP_W-1:0] expire_seconds;
  logic [IDX_W-1:0] rd_addr;
  entry_t rd_data;
  logic rd_vbit;
  wr_req_t wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      expire_seconds <= EXPIRE_RESET;
    end else if (cfg_we) begin
      expire_seconds <= cfg_wdata;
    end
  end

  pdf_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rd_vbit (rd_vbit),
    .wr      (wr)
  );

  pdf_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .plate_head     (plate_head),
    .plate_rest     (plate_rest),
    .seqno          (seqno),
    .stamp          (stamp),
    .now            (now),
    .expire_seconds (expire_seconds),
    .rd_addr        (rd_addr),
    .rd_data        (rd_data),
    .rd_vbit        (rd_vbit),
    .wr             (wr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .seen           (seen)
  );

endmodule

### rtl/pdf_checker.sv
// Port-level checks for the packet duplicate filter, bound to the top.
// Depends on pdf_pkg.
module pdf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [pdf_pkg::STATUS_W-1:0]  status,
  input logic                          seen
);
  import pdf_pkg::*;

  // busy right after a transfer in
  a_busy_after_in: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  // a new result only appears at the end of a scan
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(seen))
    else $error("stalled result changed");

  a_seen_query_only: assert property (@(posedge clk) disable iff (rst)
    out_valid && seen |-> status == ST_QUERY)
    else $error("seen set on an insert result");

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status == ST_INSERTED || status == ST_REPLACED ||
      status == ST_REJECTED || status == ST_FULL || status == ST_QUERY)
    else $error("illegal status code");

endmodule

bind packet_duplicate_filter_top pdf_checker u_pdf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .status    (status),
  .seen      (seen)
);

### test/packet_duplicate_filter_top_tb.sv
`timescale 1ns / 1ps
// Testbench for packet_duplicate_filter_top: insert and query transfers checked against
// a local copy of the source table. Depends on pdf_pkg and the packet_duplicate_filter_top RTL.
module packet_duplicate_filter_top_tb;
  import pdf_pkg::*;

  localparam int POOL_SIZE = 40;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [HEAD_W-1:0] head;
    logic [REST_W-1:0] rest;
  } plate_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic seen;
  } verdict_t;

  localparam plate_t KEY_A = {8'h5A, 64'h0123_4567_89AB_CDEF};
  localparam plate_t KEY_B = {8'hC3, 64'h8000_0000_0000_0001};
  localparam plate_t KEY_ZERO = '0;
  localparam plate_t KEY_ONES = '1;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic mode;
  logic [HEAD_W-1:0] plate_head;
  logic [REST_W-1:0] plate_rest;
  logic [SEQ_W-1:0] seqno;
  logic [TIME_W-1:0] stamp;
  logic [TIME_W-1:0] now;
  logic out_valid;
  logic out_stall;
  logic [STATUS_W-1:0] status;
  logic seen;
  logic cfg_we;
  logic [EXP_W-1:0] cfg_wdata;

  // local copy of the source table
  logic tbl_valid [ENTRIES];
  plate_t tbl_plate [ENTRIES];
  logic [SEQ_W-1:0] tbl_seq [ENTRIES];
  logic [TIME_W-1:0] tbl_stamp [ENTRIES];
  logic [EXP_W-1:0] expire_limit;

  verdict_t pending_verdicts[$];
  int error_count = 0;
  int item_count = 0;
  int cycle_count = 0;
  int verdict_tally [5] = '{default: 0};
  int seen_tally = 0;
  int send_idle_pct;
  int recv_stall_pct = 0;

  plate_t plate_pool [POOL_SIZE];
  logic [SEQ_W-1:0] pool_seq [POOL_SIZE];
  logic [TIME_W-1:0] pool_stamp [POOL_SIZE];
  logic [TIME_W-1:0] cur_time;

  packet_duplicate_filter_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .plate_head(plate_head),
    .plate_rest(plate_rest),
    .seqno(seqno),
    .stamp(stamp),
    .now(now),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .seen(seen),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("packet_duplicate_filter_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Look up the plate, apply the insert or query rules and update the table copy.
  function automatic verdict_t judge_packet(input logic m, input plate_t p,
                                            input logic [SEQ_W-1:0] s,
                                            input logic [TIME_W-1:0] st,
                                            input logic [TIME_W-1:0] nw);
    verdict_t v;
    int hit;
    int free_slot;
    logic stale;
    hit = -1;
    free_slot = -1;
    stale = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_plate[i] == p) hit = i;
      if (free_slot < 0 && !tbl_valid[i]) free_slot = i;
    end
    // age wraps modulo 2^32, so a stamp ahead of now reads as very old
    if (hit >= 0) stale = (nw - tbl_stamp[hit]) > TIME_W'(expire_limit);
    v.seen = 1'b0;
    if (m == MODE_QUERY) begin
      v.status = ST_QUERY;
      if (hit >= 0) v.seen = !stale && tbl_seq[hit] >= s;
    end else if (hit >= 0) begin
      if (stale || tbl_seq[hit] < s) begin
        tbl_plate[hit] = p;
        tbl_seq[hit] = s;
        tbl_stamp[hit] = st;
        v.status = ST_REPLACED;
      end else begin
        v.status = ST_REJECTED;
      end
    end else if (free_slot >= 0) begin
      tbl_valid[free_slot] = 1'b1;
      tbl_plate[free_slot] = p;
      tbl_seq[free_slot] = s;
      tbl_stamp[free_slot] = st;
      v.status = ST_INSERTED;
    end else begin
      v.status = ST_FULL;
    end
    return v;
  endfunction

  task automatic send_item(input logic m, input plate_t p, input logic [SEQ_W-1:0] s,
                           input logic [TIME_W-1:0] st, input logic [TIME_W-1:0] nw);
    verdict_t v;
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      repeat (($urandom_range(3) == 0) ? $urandom_range(80, 1) : $urandom_range(3, 1))
        @(negedge clk);
    end
    mode = m;
    plate_head = p.head;
    plate_rest = p.rest;
    seqno = s;
    stamp = st;
    now = nw;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = judge_packet(m, p, s, st, nw);
    pending_verdicts.push_back(v);
    item_count++;
    verdict_tally[v.status]++;
    if (v.seen) seen_tally++;
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_expiry(input logic [EXP_W-1:0] value);
    wait_for_results();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    expire_limit = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d seen %0b",
                 $time, status, seen);
        error_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time, want.status, status);
          error_count++;
        end
        if (seen !== want.seen) begin
          $display("%0t: seen mismatch: expected %0b, actual %0b", $time, want.seen, seen);
          error_count++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_item(MODE_QUERY, KEY_ZERO, '0, '0, '0);
    send_item(MODE_QUERY, KEY_ONES, '1, '1, '1);
  endtask

  task automatic test_insert_rules();
    send_item(MODE_INSERT, KEY_A, 32'd10, 32'd1000, 32'd1000);
    // equal and lower sequence on a live entry: drop
    send_item(MODE_INSERT, KEY_A, 32'd10, 32'd1001, 32'd1001);
    send_item(MODE_INSERT, KEY_A, 32'd9, 32'd1002, 32'd1002);
    send_item(MODE_INSERT, KEY_A, 32'd11, 32'd1005, 32'd1005);
    // query ignores the stamp field
    send_item(MODE_QUERY, KEY_A, 32'd11, $urandom(), 32'd1006);
    send_item(MODE_QUERY, KEY_A, 32'd12, 32'd0, 32'd1006);
  endtask

  task automatic test_field_extremes();
    send_item(MODE_INSERT, KEY_ZERO, '1, '1, '1);
    send_item(MODE_INSERT, KEY_ZERO, '0, '0, '1);
    send_item(MODE_QUERY, KEY_ZERO, '0, '0, '0);
    send_item(MODE_INSERT, KEY_ONES, '0, '0, '0);
    send_item(MODE_QUERY, KEY_ONES, '1, '0, '0);
  endtask

  task automatic test_near_keys();
    send_item(MODE_QUERY, KEY_A ^ (72'(1) << REST_W), '0, '0, 32'd1006);
    send_item(MODE_QUERY, KEY_A ^ 72'(1), '0, '0, 32'd1006);
    send_item(MODE_QUERY, KEY_A ^ (72'(1) << (REST_W - 1)), '0, '0, 32'd1006);
  endtask

  task automatic test_expiry_age();
    // age exactly at the limit is still live, one more second is not
    send_item(MODE_QUERY, KEY_A, '0, '0, 32'd1105);
    send_item(MODE_QUERY, KEY_A, '0, '0, 32'd1106);
    send_item(MODE_INSERT, KEY_A, 32'd5, 32'd1106, 32'd1106);
    // now behind the stored stamp wraps to a huge age
    send_item(MODE_QUERY, KEY_A, '0, '0, 32'd1105);
    send_item(MODE_INSERT, KEY_A, '0, 32'd2000, 32'd1000);
  endtask

  task automatic test_expiry_register();
    write_expiry('0);
    send_item(MODE_INSERT, KEY_B, 32'd7, 32'd50, 32'd50);
    send_item(MODE_QUERY, KEY_B, 32'd7, '0, 32'd50);
    send_item(MODE_QUERY, KEY_B, 32'd7, '0, 32'd51);
    write_expiry('1);
    send_item(MODE_QUERY, KEY_B, 32'd7, '0, 32'd65585);
    send_item(MODE_QUERY, KEY_B, 32'd7, '0, 32'd65586);
  endtask

  // Mostly known plates with nearby sequence numbers; fresh and one-bit-off plates as noise.
  task automatic test_random_traffic(input int count, input bit fill_ok);
    int k;
    int roll;
    int lim;
    bit pooled;
    logic m;
    plate_t p;
    logic [SEQ_W-1:0] s;
    logic [TIME_W-1:0] st;
    logic [TIME_W-1:0] nw;
    for (int n = 0; n < count; n++) begin
      lim = expire_limit;
      k = $urandom_range(POOL_SIZE - 1);
      p = plate_pool[k];
      pooled = 1'b1;
      m = ($urandom_range(99) < 40) ? MODE_QUERY : MODE_INSERT;
      roll = $urandom_range(99);
      if (roll < 4) begin
        p = {8'($urandom()), $urandom(), $urandom()};
        pooled = 1'b0;
      end else if (roll < 10) begin
        p = p ^ (72'(1) << $urandom_range(HEAD_W + REST_W - 1));
        pooled = 1'b0;
      end
      // keep stray plates out of the table until it is meant to fill
      if (!pooled && !fill_ok) m = MODE_QUERY;
      if (!pooled || $urandom_range(9) == 0) s = $urandom();
      else s = pool_seq[k] + SEQ_W'($urandom_range(6)) - SEQ_W'(3);
      roll = $urandom_range(99);
      if (roll < 60) begin
        cur_time += $urandom_range(3);
        st = cur_time;
        nw = cur_time;
      end else if (roll < 72) begin
        cur_time += $urandom_range(lim * 2 + 2, lim / 2);
        st = cur_time;
        nw = cur_time;
      end else if (roll < 80) begin
        nw = pool_stamp[k] + TIME_W'(lim) + TIME_W'($urandom_range(1));
        st = nw;
      end else if (roll < 88) begin
        nw = cur_time;
        st = cur_time + $urandom_range(5000, 1);
      end else if (roll < 94) begin
        nw = cur_time - $urandom_range(50, 1);
        st = nw;
      end else begin
        st = $urandom();
        nw = $urandom();
      end
      send_item(m, p, s, st, nw);
      if (pooled && m == MODE_INSERT) begin
        pool_seq[k] = s;
        pool_stamp[k] = st;
      end
    end
  endtask

  task automatic test_table_full();
    int used;
    do begin
      cur_time += 1;
      send_item(MODE_INSERT, {8'($urandom()), $urandom(), $urandom()}, $urandom(),
                cur_time, cur_time);
      used = 0;
      for (int i = 0; i < ENTRIES; i++) used += tbl_valid[i];
    end while (used < ENTRIES);
    repeat (4)
      send_item(MODE_INSERT, {8'($urandom()), $urandom(), $urandom()}, $urandom(),
                cur_time, cur_time);
    send_item(MODE_QUERY, {8'($urandom()), $urandom(), $urandom()}, '0, '0, cur_time);
    // a stored plate can still be refreshed in a full table
    pool_seq[0] = pool_seq[0] + 1;
    pool_stamp[0] = cur_time;
    send_item(MODE_INSERT, plate_pool[0], pool_seq[0], cur_time, cur_time);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_INSERT;
    plate_head = '0;
    plate_rest = '0;
    seqno = '0;
    stamp = '0;
    now = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_idle_pct = 35;
    recv_stall_pct = 66;
    expire_limit = EXPIRE_RESET;
    for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_table();
    test_insert_rules();
    test_field_extremes();
    test_near_keys();
    test_expiry_age();
    test_expiry_register();

    cur_time = $urandom();
    for (int k = 0; k < POOL_SIZE; k++) begin
      if (k < 8) plate_pool[k] = KEY_A ^ (72'(1) << $urandom_range(HEAD_W + REST_W - 1));
      else plate_pool[k] = {8'($urandom()), $urandom(), $urandom()};
      pool_seq[k] = $urandom();
      pool_stamp[k] = cur_time;
    end
    write_expiry(EXPIRE_RESET);
    test_random_traffic(240, 1'b0);

    send_idle_pct = 66;
    recv_stall_pct = 35;
    write_expiry(EXP_W'($urandom_range(65534, 1)));
    test_table_full();
    test_random_traffic(230, 1'b1);

    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_expiry('0);
    test_random_traffic(115, 1'b1);
    write_expiry('1);
    test_random_traffic(115, 1'b1);

    wait_for_results();
    repeat (ENTRIES + 8) @(posedge clk);
    $display("Sent %0d packets: %0d new, %0d replaced, %0d rejected, %0d hit a full table,",
             item_count, verdict_tally[ST_INSERTED], verdict_tally[ST_REPLACED],
             verdict_tally[ST_REJECTED], verdict_tally[ST_FULL]);
    $display("%0d queries (%0d found live), expiry limits 0, 100, 65535 and one random.",
             verdict_tally[ST_QUERY], seen_tally);
    if (error_count == 0) begin
      $display("packet_duplicate_filter_top verification clean");
    end else begin
      $display("packet_duplicate_filter_top verification failed");
    end
    $finish;
  end

endmodule

### packet_duplicate_filter_top.f
rtl/pdf_pkg.sv
rtl/pdf_table.sv
rtl/pdf_cmp.sv
rtl/pdf_ctrl.sv
rtl/packet_duplicate_filter_top.sv
rtl/pdf_checker.sv
test/packet_duplicate_filter_top_tb.sv
